// ----- design/conv2d_valid_window_defines.svh -----
// Assertion macros shared by the front end and queue design files.
`ifndef CONV2D_VALID_WINDOW_DEFINES_SVH
`define CONV2D_VALID_WINDOW_DEFINES_SVH

// Flag any clock edge out of reset at which cond holds.
`define CVW_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Require cons in the cycle after ante.
`define CVW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cvw_pkg.sv -----
// Shared types and constants of the convolution window block.
package cvw_pkg;

	localparam logic OPC_WEIGHT = 1'b0;
	localparam logic OPC_PIXEL  = 1'b1;

	localparam int OUT_IDX_W = 5;
	localparam int SUM_W     = 32;
	localparam int FRAC_BITS = 8;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Classification of one accepted item, made by the front end.
	typedef struct packed {
		logic                 is_pixel;
		logic                 emit;
		logic                 last;
		logic [OUT_IDX_W-1:0] out_row;
		logic [OUT_IDX_W-1:0] out_col;
	} cvw_tag_t;

endpackage

// ----- design/cvw_in_if.sv -----
// Input channel: opcode and sample with valid/ready handshake.
interface cvw_in_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic signed [DATA_WIDTH-1:0] sample_value;

	modport source (output valid, output opcode, output sample_value, input ready);
	modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

// ----- design/cvw_out_if.sv -----
// Result channel: window sum, position and frame flag with valid/ready handshake.
interface cvw_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [cvw_pkg::SUM_W-1:0]  conv_sum;
	logic [cvw_pkg::OUT_IDX_W-1:0]     out_row;
	logic [cvw_pkg::OUT_IDX_W-1:0]     out_col;
	logic                              frame_last;

	modport source (output valid, output conv_sum, output out_row, output out_col,
		output frame_last, input ready);
	modport sink   (input valid, input conv_sum, input out_row, input out_col,
		input frame_last, output ready);
endinterface

// ----- design/conv2d_valid_window.sv -----
// Top level of the streaming valid-mode 2D convolution window.
// Usage:
//   sample channel: opcode 0 transfers the next kernel weight (row-major slot,
//   wrapping after the last slot); opcode 1 transfers the next image pixel in
//   row-major order. Weights may be reloaded at any time and apply to later
//   results only.
//   result channel: one transfer per pixel that completes a full window, with
//   the Q24.8 saturated, round-to-nearest sum, its output row and column, and
//   frame_last on the bottom-right window of the frame.
// Throughput: one item per cycle, sustained, while the receiver takes results.
// Pipeline: a completing pixel passes the queue, line buffer read, window
//   update, multiply, row sums, total, clamp, round and saturate before its
//   result is valid.
// Stall: a stalled result freezes the back pipeline; the 4-entry queue then
//   fills and sample.ready drops until the result is taken.
// Reset: weights, window, weight slot and pixel position clear to zero; the
//   line buffer is not cleared, as every window that yields a result reads only
//   columns written earlier in the same frame.
module conv2d_valid_window #(
	parameter int KERNEL_ROWS = 5,
	parameter int KERNEL_COLS = 5,
	parameter int IMAGE_ROWS  = 32,
	parameter int IMAGE_COLS  = 32,
	parameter int DATA_WIDTH  = 16
) (
	input logic       clk,
	input logic       arst_n,
	cvw_in_if.sink    sample,
	cvw_out_if.source result
);
	import cvw_pkg::*;

	localparam int KSIZE  = KERNEL_ROWS * KERNEL_COLS;
	localparam int KIDX_W = (KSIZE > 1) ? $clog2(KSIZE) : 1;
	localparam int COL_W  = $clog2(IMAGE_COLS);
	localparam int ENT_W  = KIDX_W + COL_W + DATA_WIDTH;

	// Front to queue: tagged item plus weight slot, column and sample.
	logic             push;
	logic             full;
	cvw_tag_t         push_tag;
	logic [ENT_W-1:0] push_data;

	// Queue to back: head item.
	logic             pop;
	logic             empty;
	cvw_tag_t         head_tag;
	logic [ENT_W-1:0] head_data;

	cvw_front #(
		.KERNEL_ROWS (KERNEL_ROWS),
		.KERNEL_COLS (KERNEL_COLS),
		.IMAGE_ROWS  (IMAGE_ROWS),
		.IMAGE_COLS  (IMAGE_COLS),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.full     (full),
		.push     (push),
		.ent_tag  (push_tag),
		.ent_data (push_data)
	);

	cvw_queue #(
		.DATA_W (ENT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_tag   (push_tag),
		.in_data  (push_data),
		.pop      (pop),
		.out_tag  (head_tag),
		.out_data (head_data),
		.full     (full),
		.empty    (empty)
	);

	cvw_back #(
		.KERNEL_ROWS (KERNEL_ROWS),
		.KERNEL_COLS (KERNEL_COLS),
		.IMAGE_COLS  (IMAGE_COLS),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.q_tag  (head_tag),
		.q_data (head_data),
		.pop    (pop),
		.result (result)
	);

endmodule

// ----- design/cvw_front.sv -----
// Front end: accept items, track weight slot and pixel position, tag each item.
`include "conv2d_valid_window_defines.svh"

module cvw_front #(
	parameter int KERNEL_ROWS = 5,
	parameter int KERNEL_COLS = 5,
	parameter int IMAGE_ROWS  = 32,
	parameter int IMAGE_COLS  = 32,
	parameter int DATA_WIDTH  = 16,
	localparam int KSIZE      = KERNEL_ROWS * KERNEL_COLS,
	localparam int KIDX_W     = (KSIZE > 1) ? $clog2(KSIZE) : 1,
	localparam int COL_W      = $clog2(IMAGE_COLS),
	localparam int ENT_W      = KIDX_W + COL_W + DATA_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	cvw_in_if.sink            sample,
	input  logic              full,
	output logic              push,
	output cvw_pkg::cvw_tag_t ent_tag,
	output logic [ENT_W-1:0]  ent_data
);
	import cvw_pkg::*;

	localparam int ROW_W = $clog2(IMAGE_ROWS);

	logic [KIDX_W-1:0] widx_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              is_pixel;
	logic              at_last_row;
	logic              at_last_col;
	logic [ROW_W-1:0]  row_off;
	logic [COL_W-1:0]  col_off;

	assign sample.ready = !full;
	assign push         = sample.valid && !full;
	assign is_pixel     = (sample.opcode == OPC_PIXEL);
	assign at_last_row  = (row_q == ROW_W'(IMAGE_ROWS - 1));
	assign at_last_col  = (col_q == COL_W'(IMAGE_COLS - 1));
	assign row_off      = row_q - ROW_W'(KERNEL_ROWS - 1);
	assign col_off      = col_q - COL_W'(KERNEL_COLS - 1);

	always_comb begin
		ent_tag.is_pixel = is_pixel;
		ent_tag.emit     = (32'(row_q) >= 32'(KERNEL_ROWS - 1)) &&
			(32'(col_q) >= 32'(KERNEL_COLS - 1));
		ent_tag.last     = at_last_row && at_last_col;
		ent_tag.out_row  = OUT_IDX_W'(row_off);
		ent_tag.out_col  = OUT_IDX_W'(col_off);
	end

	assign ent_data = {widx_q, col_q, sample.sample_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (push) begin
			if (is_pixel) begin
				if (at_last_col) begin
					col_q <= '0;
					row_q <= at_last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else begin
				widx_q <= (widx_q == KIDX_W'(KSIZE - 1)) ? '0 : widx_q + 1'b1;
			end
		end
	end

	`CVW_ASSERT_NEXT(a_frame_wrap, (push && is_pixel && at_last_row && at_last_col), ((row_q == '0) && (col_q == '0)), "pixel position did not wrap after the last pixel of the frame")

endmodule

// ----- design/cvw_queue.sv -----
// Short queue between the front end and the back end.
`include "conv2d_valid_window_defines.svh"

module cvw_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cvw_pkg::cvw_tag_t in_tag,
	input  logic [DATA_W-1:0] in_data,
	input  logic              pop,
	output cvw_pkg::cvw_tag_t out_tag,
	output logic [DATA_W-1:0] out_data,
	output logic              full,
	output logic              empty
);
	import cvw_pkg::*;

	cvw_tag_t          tag_mem  [QDEPTH];
	logic [DATA_W-1:0] data_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign out_tag  = tag_mem[rd_ptr_q];
	assign out_data = data_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			tag_mem[wr_ptr_q]  <= in_tag;
			data_mem[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CVW_ASSERT_NEVER(a_push_full, (push && full), "queue written while full")
	`CVW_ASSERT_NEVER(a_pop_empty, (pop && empty), "queue read while empty")

endmodule

// ----- design/cvw_back.sv -----
// Back end: line buffer, window, weights, multiply-add tree, rounding and result register.
module cvw_back #(
	parameter int KERNEL_ROWS = 5,
	parameter int KERNEL_COLS = 5,
	parameter int IMAGE_COLS  = 32,
	parameter int DATA_WIDTH  = 16,
	localparam int KSIZE      = KERNEL_ROWS * KERNEL_COLS,
	localparam int KIDX_W     = (KSIZE > 1) ? $clog2(KSIZE) : 1,
	localparam int COL_W      = $clog2(IMAGE_COLS),
	localparam int ENT_W      = KIDX_W + COL_W + DATA_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  cvw_pkg::cvw_tag_t q_tag,
	input  logic [ENT_W-1:0]  q_data,
	output logic              pop,
	cvw_out_if.source         result
);
	import cvw_pkg::*;

	localparam int PROD_W   = 2 * DATA_WIDTH;
	localparam int ROWSUM_W = PROD_W + $clog2(KERNEL_COLS) + 1;
	localparam int ACC_W    = ROWSUM_W + $clog2(KERNEL_ROWS) + 1;
	localparam int EXT_W    = (ACC_W > 64) ? ACC_W : 64;
	localparam int LB_ROWS  = (KERNEL_ROWS > 1) ? KERNEL_ROWS - 1 : 1;
	localparam int LB_W     = LB_ROWS * DATA_WIDTH;

	localparam logic signed [EXT_W-1:0] ACC_LIM    = EXT_W'(64'sd1 <<< 61);
	localparam logic signed [EXT_W-1:0] ACC_LIM_N  = -ACC_LIM;
	localparam logic signed [EXT_W-1:0] ROUND_HALF = EXT_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [EXT_W-1:0] SAT_HI     = EXT_W'(32'sh7fff_ffff);
	localparam logic signed [EXT_W-1:0] SAT_LO     = ~SAT_HI;

	logic                         adv;
	logic [KIDX_W-1:0]            q_widx;
	logic [COL_W-1:0]             q_col;

	logic                         v_s1;
	cvw_tag_t                     tag_s1;
	logic signed [DATA_WIDTH-1:0] val_s1;
	logic [KIDX_W-1:0]            widx_s1;
	logic [COL_W-1:0]             col_s1;

	logic signed [DATA_WIDTH-1:0] weight_q [KSIZE];
	logic signed [DATA_WIDTH-1:0] window_q [KERNEL_ROWS][KERNEL_COLS];
	logic signed [DATA_WIDTH-1:0] col_new  [KERNEL_ROWS];

	logic                         v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	cvw_tag_t                     tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic signed [PROD_W-1:0]     prod_c    [KSIZE];
	logic signed [PROD_W-1:0]     prod_s3   [KSIZE];
	logic signed [ROWSUM_W-1:0]   rowsum_c  [KERNEL_ROWS];
	logic signed [ROWSUM_W-1:0]   rowsum_s4 [KERNEL_ROWS];
	logic signed [ACC_W-1:0]      total_c;
	logic signed [ACC_W-1:0]      total_s5;
	logic signed [EXT_W-1:0]      ext_c;
	logic signed [EXT_W-1:0]      clamp_s6;
	logic signed [EXT_W-1:0]      rnd_c;
	logic signed [EXT_W-1:0]      round_s7;
	logic signed [SUM_W-1:0]      sat_c;

	logic                         out_valid_q;
	logic signed [SUM_W-1:0]      conv_sum_q;
	logic [OUT_IDX_W-1:0]         out_row_q;
	logic [OUT_IDX_W-1:0]         out_col_q;
	logic                         last_q;

	// The whole back pipeline advances together; it holds only on a stalled result.
	assign adv    = !out_valid_q || result.ready;
	assign pop    = adv && !empty;
	assign q_widx = q_data[ENT_W-1 -: KIDX_W];
	assign q_col  = q_data[DATA_WIDTH +: COL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tag_s1  <= q_tag;
			val_s1  <= $signed(q_data[DATA_WIDTH-1:0]);
			widx_s1 <= q_widx;
			col_s1  <= q_col;
		end
	end

	// Line buffer: one entry per image column, newest row in the low slice.
	if (KERNEL_ROWS > 1) begin : g_lb
		logic [LB_W-1:0] lb_mem [IMAGE_COLS];
		logic [LB_W-1:0] lb_rd_q;
		logic [LB_W-1:0] lb_wr;

		always_ff @(posedge clk) begin
			if (pop) lb_rd_q <= lb_mem[q_col];
			if (adv && v_s1 && tag_s1.is_pixel) lb_mem[col_s1] <= lb_wr;
		end

		always_comb begin
			lb_wr[DATA_WIDTH-1:0] = val_s1;
			for (int k = 1; k < LB_ROWS; k++) begin
				lb_wr[k*DATA_WIDTH +: DATA_WIDTH] = lb_rd_q[(k-1)*DATA_WIDTH +: DATA_WIDTH];
			end
			for (int x = 0; x < KERNEL_ROWS - 1; x++) begin
				col_new[x] = $signed(lb_rd_q[(KERNEL_ROWS-2-x)*DATA_WIDTH +: DATA_WIDTH]);
			end
			col_new[KERNEL_ROWS-1] = val_s1;
		end
	end else begin : g_no_lb
		assign col_new[0] = val_s1;
	end

	// Window shifts left on a pixel; a weight item overwrites its slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KSIZE; k++) weight_q[k] <= '0;
			for (int x = 0; x < KERNEL_ROWS; x++) begin
				for (int y = 0; y < KERNEL_COLS; y++) window_q[x][y] <= '0;
			end
		end else if (adv && v_s1) begin
			if (tag_s1.is_pixel) begin
				for (int x = 0; x < KERNEL_ROWS; x++) begin
					for (int y = 0; y < KERNEL_COLS - 1; y++) begin
						window_q[x][y] <= window_q[x][y+1];
					end
					window_q[x][KERNEL_COLS-1] <= col_new[x];
				end
			end else begin
				weight_q[widx_s1] <= val_s1;
			end
		end
	end

	always_comb begin
		for (int x = 0; x < KERNEL_ROWS; x++) begin
			for (int y = 0; y < KERNEL_COLS; y++) begin
				prod_c[x*KERNEL_COLS+y] = weight_q[x*KERNEL_COLS+y] * window_q[x][y];
			end
		end
	end

	always_comb begin
		logic signed [ROWSUM_W-1:0] acc;
		for (int x = 0; x < KERNEL_ROWS; x++) begin
			acc = '0;
			for (int y = 0; y < KERNEL_COLS; y++) begin
				acc = acc + ROWSUM_W'(prod_s3[x*KERNEL_COLS+y]);
			end
			rowsum_c[x] = acc;
		end
	end

	always_comb begin
		total_c = '0;
		for (int x = 0; x < KERNEL_ROWS; x++) begin
			total_c = total_c + ACC_W'(rowsum_s4[x]);
		end
	end

	always_comb begin
		ext_c = EXT_W'(total_s5);
		rnd_c = clamp_s6 + ROUND_HALF;
		priority if (round_s7 > SAT_HI) begin
			sat_c = SUM_W'(SAT_HI);
		end else if (round_s7 < SAT_LO) begin
			sat_c = SUM_W'(SAT_LO);
		end else begin
			sat_c = SUM_W'(round_s7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= v_s1 && tag_s1.is_pixel && tag_s1.emit;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2    <= tag_s1;
			tag_s3    <= tag_s2;
			prod_s3   <= prod_c;
			tag_s4    <= tag_s3;
			rowsum_s4 <= rowsum_c;
			tag_s5    <= tag_s4;
			total_s5  <= total_c;
			tag_s6    <= tag_s5;
			priority if (ext_c > ACC_LIM) begin
				clamp_s6 <= ACC_LIM;
			end else if (ext_c < ACC_LIM_N) begin
				clamp_s6 <= ACC_LIM_N;
			end else begin
				clamp_s6 <= ext_c;
			end
			tag_s7     <= tag_s6;
			round_s7   <= rnd_c >>> FRAC_BITS;
			conv_sum_q <= sat_c;
			out_row_q  <= tag_s7.out_row;
			out_col_q  <= tag_s7.out_col;
			last_q     <= tag_s7.last;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.conv_sum   = conv_sum_q;
	assign result.out_row    = out_row_q;
	assign result.out_col    = out_col_q;
	assign result.frame_last = last_q;

endmodule

// ----- tb/sv/conv2d_valid_window_test.sv -----
// Self-checking testbench for the streaming 5x5 valid-mode convolution window.
module conv2d_valid_window_test;
	import cvw_pkg::*;

	localparam int KROWS = 5;
	localparam int KCOLS = 5;
	localparam int IROWS = 32;
	localparam int ICOLS = 32;
	localparam int DW    = 16;
	localparam int TAPS  = KROWS * KCOLS;

	// Result latency, in clock edges after the completing pixel transfer.
	localparam int PIPE_LATENCY = 8;
	// Pixels in the random stream: one full frame plus part of the next.
	localparam int STREAM_PIXELS = 1350;
	// Sender gaps and receiver stalls stop for this many trailing items.
	localparam int QUIET_TAIL = 200;
	// Transfer counts at which the sender drains and the receiver holds off.
	localparam int DRAIN_AT     = 700;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 100;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	typedef struct {
		logic                 opcode;
		logic signed [DW-1:0] value;
	} sample_item_t;

	typedef struct {
		logic signed [SUM_W-1:0]  sum;
		logic [OUT_IDX_W-1:0]     row;
		logic [OUT_IDX_W-1:0]     col;
		logic                     last;
	} window_sum_t;

	logic clk;
	logic arst_n;

	cvw_in_if #(.DATA_WIDTH(DW)) sample_ch ();
	cvw_out_if result_ch ();

	conv2d_valid_window #(
		.KERNEL_ROWS(KROWS),
		.KERNEL_COLS(KCOLS),
		.IMAGE_ROWS (IROWS),
		.IMAGE_COLS (ICOLS),
		.DATA_WIDTH (DW)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	// Items waiting to be offered, and window sums waiting to come out.
	sample_item_t pending_samples[$];
	window_sum_t  window_sums_due[$];

	// Shadow copy of the block's kernel, line buffers, window and position.
	logic signed [DW-1:0] kernel_taps [TAPS];
	int unsigned          kernel_slot;
	logic signed [DW-1:0] line_rows [KROWS-1][ICOLS];
	logic signed [DW-1:0] window_px [KROWS][KCOLS];
	int unsigned          pix_row;
	int unsigned          pix_col;

	int          errors;
	int          items_sent;
	int          gap_left;
	int          stall_left;
	bit          draining;
	bit          drained_once;
	logic        hold_off;
	logic        quiet_tail;
	window_sum_t got_sum;
	window_sum_t want_sum;

	// Advance the shadow image by one transfer; queue a window sum if one completes.
	task automatic correlate_sample(input logic opc, input logic signed [DW-1:0] val);
		logic signed [DW-1:0] column [KROWS];
		longint acc;
		longint rounded;
		window_sum_t due;
		if (opc == OPC_WEIGHT) begin
			kernel_taps[kernel_slot] = val;
			kernel_slot = (kernel_slot + 1 >= TAPS) ? 0 : kernel_slot + 1;
		end else begin
			// Build the new window column, oldest row on top.
			for (int x = 0; x < KROWS - 1; x++)
				column[x] = line_rows[KROWS-2-x][pix_col];
			column[KROWS-1] = val;
			// Age this column of the line buffers.
			for (int k = KROWS - 2; k >= 1; k--)
				line_rows[k][pix_col] = line_rows[k-1][pix_col];
			line_rows[0][pix_col] = val;
			// Shift the window left and insert the new column at the right.
			for (int x = 0; x < KROWS; x++) begin
				for (int y = 0; y < KCOLS - 1; y++)
					window_px[x][y] = window_px[x][y+1];
				window_px[x][KCOLS-1] = column[x];
			end
			if (pix_row >= KROWS - 1 && pix_col >= KCOLS - 1) begin
				acc = 0;
				for (int x = 0; x < KROWS; x++)
					for (int y = 0; y < KCOLS; y++)
						acc += longint'(kernel_taps[x*KCOLS+y]) * longint'(window_px[x][y]);
				// Round half up to Q24.8: arithmetic shift is a floor division.
				rounded = (acc + 128) >>> FRAC_BITS;
				if (rounded > SUM_MAX) rounded = SUM_MAX;
				if (rounded < SUM_MIN) rounded = SUM_MIN;
				due.sum  = rounded[SUM_W-1:0];
				due.row  = OUT_IDX_W'(pix_row - (KROWS - 1));
				due.col  = OUT_IDX_W'(pix_col - (KCOLS - 1));
				due.last = (pix_row == IROWS - 1) && (pix_col == ICOLS - 1);
				window_sums_due.push_back(due);
			end
			pix_col++;
			if (pix_col >= ICOLS) begin
				pix_col = 0;
				pix_row = (pix_row + 1 >= IROWS) ? 0 : pix_row + 1;
			end
		end
	endtask

	// Free-running clock, period of two units.
	always #1 clk = ~clk;

	// Sender: offer queued items, hold valid until the transfer, idle in bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				correlate_sample(sample_ch.opcode, sample_ch.sample_value);
				items_sent++;
				// Stop once mid-frame until every queued window sum has come out.
				if (items_sent == DRAIN_AT && !drained_once) begin
					draining     = 1'b1;
					drained_once = 1'b1;
				end
			end
			if (draining && window_sums_due.size() == 0)
				draining = 1'b0;
			quiet_tail <= (pending_samples.size() < QUIET_TAIL);

			if (sample_ch.valid && !sample_ch.ready) begin
				// Hold the offered item until it is taken.
			end else if (draining || gap_left > 0 || pending_samples.size() == 0) begin
				sample_ch.valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else if (pending_samples.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 6) - 1;
				sample_ch.valid <= 1'b0;
			end else begin
				sample_ch.valid        <= 1'b1;
				sample_ch.opcode       <= pending_samples[0].opcode;
				sample_ch.sample_value <= pending_samples[0].value;
				void'(pending_samples.pop_front());
			end
		end
	end

	// Receiver: check each window sum against the oldest one due, stall in bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got_sum.sum  = result_ch.conv_sum;
				got_sum.row  = result_ch.out_row;
				got_sum.col  = result_ch.out_col;
				got_sum.last = result_ch.frame_last;
				if (window_sums_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: sum %0d row %0d col %0d last %0b",
							got_sum.sum, got_sum.row, got_sum.col, got_sum.last);
				end else begin
					want_sum = window_sums_due.pop_front();
					if (got_sum.sum !== want_sum.sum || got_sum.row !== want_sum.row ||
						got_sum.col !== want_sum.col || got_sum.last !== want_sum.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected sum %0d row %0d col %0d last %0b, got sum %0d row %0d col %0d last %0b",
								want_sum.sum, want_sum.row, want_sum.col, want_sum.last,
								got_sum.sum, got_sum.row, got_sum.col, got_sum.last);
					end
				end
			end

			if (hold_off === 1'b1) begin
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (quiet_tail !== 1'b1 && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off: the input queue fills and sample.ready must drop.
	initial begin
		hold_off = 1'b0;
		wait (items_sent >= HOLD_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog: end the run with an error verdict once its time limit is reached, progress or not.
	initial begin
		#400000;
		$display("conv2d_valid_window_test: errors");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		logic signed [DW-1:0] directed_taps [TAPS+2];
		logic signed [DW-1:0] v;
		sample_item_t         item;
		int                   pixels_left;

		clk                    = 1'b0;
		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.opcode       = OPC_WEIGHT;
		sample_ch.sample_value = '0;
		result_ch.ready        = 1'b0;
		quiet_tail             = 1'b0;
		errors                 = 0;
		items_sent             = 0;
		gap_left               = 0;
		stall_left             = 0;
		draining               = 1'b0;
		drained_once           = 1'b0;
		kernel_slot            = 0;
		pix_row                = 0;
		pix_col                = 0;
		for (int i = 0; i < TAPS; i++)
			kernel_taps[i] = '0;
		for (int x = 0; x < KROWS; x++)
			for (int y = 0; y < KCOLS; y++)
				window_px[x][y] = '0;
		for (int k = 0; k < KROWS - 1; k++)
			for (int c = 0; c < ICOLS; c++)
				line_rows[k][c] = '0;

		// Directed kernel: field extremes and sign patterns, then two extra
		// weights that wrap the load slot back over the first taps.
		directed_taps = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
			16'sh0100, 16'shff00, 16'sh5555, 16'shaaaa, 16'sh8000,
			16'sh7fff, 16'sh0080, 16'shff80, 16'sh1234, 16'shedcb,
			16'sh8001, 16'sh7ffe, 16'sh00ff, 16'shff01, 16'sh4000,
			16'shc000, 16'sh0002, 16'shfffe, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh8000};
		for (int i = 0; i < TAPS + 2; i++) begin
			item.opcode = OPC_WEIGHT;
			item.value  = directed_taps[i];
			pending_samples.push_back(item);
		end

		// Random stream: mostly pixels, with weight reloads mixed in mid-frame.
		pixels_left = STREAM_PIXELS;
		while (pixels_left > 0) begin
			case ($urandom_range(0, 7))
				0:       v = 16'sh8000;
				1:       v = 16'sh7fff;
				2:       v = DW'(int'($urandom_range(0, 511)) - 256);
				default: v = DW'($urandom);
			endcase
			if ($urandom_range(0, 15) == 0) begin
				item.opcode = OPC_WEIGHT;
			end else begin
				item.opcode = OPC_PIXEL;
				pixels_left--;
			end
			item.value = v;
			pending_samples.push_back(item);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the stream to go in and every window sum to come out.
		while (pending_samples.size() != 0 || sample_ch.valid === 1'b1 ||
			window_sums_due.size() != 0)
			@(posedge clk);
		// Let any stray late result surface before the verdict.
		repeat (3 * PIPE_LATENCY) @(posedge clk);

		if (errors == 0)
			$display("conv2d_valid_window_test: clean");
		else
			$display("conv2d_valid_window_test: errors");
		$finish;
	end

endmodule
